>>> design/assert_macros.svh
// assertion helpers shared by the lexer modules
// every use samples on i_clk and is disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BTL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("lexer assertion failed");
`define BTL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lexer assertion failed");
`define BTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lexer assertion failed");
`else
`define BTL_ASSERT_ALWAYS(label, cond)
`define BTL_ASSERT_IMPL(label, ante, cons)
`define BTL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/btl_pkg.sv
`default_nettype none
package btl_pkg;

    localparam int MAX_COMMENT_DEPTH_DEF = 255;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_TEXT  = 3'd1,
        MODE_STR   = 3'd2,
        MODE_LINE  = 3'd3,
        MODE_BLOCK = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_SLASH = 2'd1,
        HELD_STAR  = 2'd2
    } t_held;

    localparam logic [3:0] KIND_TEXT        = 4'd0;
    localparam logic [3:0] KIND_STRING      = 4'd1;
    localparam logic [3:0] KIND_OPEN_PAREN  = 4'd2;
    localparam logic [3:0] KIND_OPEN_SQUARE = 4'd3;
    localparam logic [3:0] KIND_OPEN_BRACE  = 4'd4;
    localparam logic [3:0] KIND_CLOSE_PAREN = 4'd5;
    localparam logic [3:0] KIND_CLOSE_SQUARE = 4'd6;
    localparam logic [3:0] KIND_CLOSE_BRACE = 4'd7;
    localparam logic [3:0] KIND_NONE        = 4'd8;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNTERM_STR  = 2'd1;
    localparam logic [1:0] ST_DEPTH_OVF   = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] line;
        logic [1:0]  status;
        logic        final_flag;
    } t_token;

    // up to two tokens handed from the lexer core to the result queue
    typedef struct packed {
        logic [1:0] count;
        t_token     slot0;
        t_token     slot1;
    } t_push;

    function automatic t_token mk_token(input logic [3:0] kind, input logic [31:0] offset,
                                        input logic [31:0] length, input logic [31:0] line,
                                        input logic [1:0] status);
        t_token t;
        t.kind       = kind;
        t.offset     = offset;
        t.length     = length;
        t.line       = line;
        t.status     = status;
        t.final_flag = 1'b0;
        return t;
    endfunction

    function automatic logic ends_text(input logic [7:0] b);
        return (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_LSQ) || (b == CH_RSQ) ||
               (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_DQUOTE) ||
               (b == CH_SQUOTE) || (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_CR) || (b == CH_BS) || (b == CH_FF) || (b == CH_NUL) ||
               (b == CH_COMMA) || (b == CH_SEMI);
    endfunction

endpackage
`default_nettype wire

>>> design/btl_if.sv
`default_nettype none
interface btl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_source;

    modport source (output valid, output data_byte, output end_of_source, input ready);
    modport sink (input valid, input data_byte, input end_of_source, output ready);
endinterface

interface btl_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] token_offset;
    logic [31:0] token_length;
    logic [31:0] line_number;
    logic [1:0]  status;
    logic        final_result;

    modport source (output valid, output token_kind, output token_offset,
                    output token_length, output line_number, output status,
                    output final_result, input ready);
    modport sink (input valid, input token_kind, input token_offset,
                  input token_length, input line_number, input status,
                  input final_result, output ready);
endinterface
`default_nettype wire

>>> design/btl_core.sv
`default_nettype none
module btl_core #(
    parameter int MAX_COMMENT_DEPTH = btl_pkg::MAX_COMMENT_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_data,
    input  wire logic          i_last,
    output btl_pkg::t_push     o_push
);

    localparam int DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] MAX_D = DEPTH_W'(MAX_COMMENT_DEPTH);

    btl_pkg::t_mode      r_mode, n_mode;
    btl_pkg::t_held      r_held, n_held;
    logic [31:0]         r_pos, n_pos;
    logic [31:0]         r_line, n_line;
    logic [31:0]         r_start, n_start;
    logic                r_qsingle, n_qsingle;
    logic                r_esc, n_esc;
    logic [DEPTH_W-1:0]  r_depth, n_depth;

    logic               text_hit;
    logic               idle_hit;
    logic               c0v, civ, cfv;
    btl_pkg::t_token    c0, ci, cf;
    logic [7:0]         qchar;
    logic [DEPTH_W-1:0] dec_depth;

    always_comb begin
        n_mode    = r_mode;
        n_held    = r_held;
        n_pos     = r_pos + 32'd1;
        n_line    = r_line;
        n_start   = r_start;
        n_qsingle = r_qsingle;
        n_esc     = r_esc;
        n_depth   = r_depth;
        text_hit  = 1'b0;
        idle_hit  = 1'b0;
        c0v       = 1'b0;
        civ       = 1'b0;
        cfv       = 1'b0;
        c0        = '0;
        ci        = '0;
        cf        = '0;
        qchar     = r_qsingle ? btl_pkg::CH_SQUOTE : btl_pkg::CH_DQUOTE;
        dec_depth = (r_depth != '0) ? r_depth - 1'b1 : r_depth;
        o_push    = '0;

        unique case (r_mode)
            btl_pkg::MODE_TEXT: begin
                text_hit = 1'b1;
            end
            btl_pkg::MODE_STR: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_data == qchar) begin
                    c0v    = 1'b1;
                    c0     = btl_pkg::mk_token(btl_pkg::KIND_STRING, r_start, r_pos - r_start,
                                               r_line, btl_pkg::ST_OK);
                    n_mode = btl_pkg::MODE_IDLE;
                end else if (i_data == btl_pkg::CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (i_data == btl_pkg::CH_LF) begin
                    n_line = r_line + 32'd1;
                end
            end
            btl_pkg::MODE_LINE: begin
                if (i_data == btl_pkg::CH_LF) begin
                    n_line = r_line + 32'd1;
                    n_mode = btl_pkg::MODE_IDLE;
                end
            end
            btl_pkg::MODE_BLOCK: begin
                if (i_data == btl_pkg::CH_LF) begin
                    n_line = r_line + 32'd1;
                end
                if (r_held == btl_pkg::HELD_SLASH && i_data == btl_pkg::CH_STAR) begin
                    n_held = btl_pkg::HELD_NONE;
                    if (r_depth >= MAX_D) begin
                        c0v = 1'b1;
                        c0  = btl_pkg::mk_token(btl_pkg::KIND_NONE, r_pos - 32'd1, 32'd2,
                                                r_line, btl_pkg::ST_DEPTH_OVF);
                    end else begin
                        n_depth = r_depth + 1'b1;
                    end
                end else if (r_held == btl_pkg::HELD_STAR && i_data == btl_pkg::CH_SLASH) begin
                    n_held  = btl_pkg::HELD_NONE;
                    n_depth = dec_depth;
                    if (dec_depth == '0) begin
                        n_mode = btl_pkg::MODE_IDLE;
                    end
                end else if (i_data == btl_pkg::CH_SLASH) begin
                    n_held = btl_pkg::HELD_SLASH;
                end else if (i_data == btl_pkg::CH_STAR) begin
                    n_held = btl_pkg::HELD_STAR;
                end else begin
                    n_held = btl_pkg::HELD_NONE;
                end
            end
            default: begin
                n_mode = btl_pkg::MODE_IDLE;
                n_held = btl_pkg::HELD_NONE;
                if (r_held == btl_pkg::HELD_SLASH) begin
                    if (i_data == btl_pkg::CH_SLASH) begin
                        n_mode = btl_pkg::MODE_LINE;
                    end else if (i_data == btl_pkg::CH_STAR) begin
                        n_mode  = btl_pkg::MODE_BLOCK;
                        n_depth = DEPTH_W'(1);
                    end else begin
                        n_mode   = btl_pkg::MODE_TEXT;
                        text_hit = 1'b1;
                    end
                end else begin
                    idle_hit = 1'b1;
                end
            end
        endcase

        // a text run closes on a delimiter, which is then handled as a fresh byte
        if (text_hit && btl_pkg::ends_text(i_data)) begin
            c0v      = 1'b1;
            c0       = btl_pkg::mk_token(btl_pkg::KIND_TEXT, r_start, r_pos - r_start,
                                         r_line, btl_pkg::ST_OK);
            n_mode   = btl_pkg::MODE_IDLE;
            idle_hit = 1'b1;
        end

        if (idle_hit) begin
            if (i_data <= btl_pkg::CH_SPACE) begin
                if (i_data == btl_pkg::CH_LF) begin
                    n_line = r_line + 32'd1;
                end
            end else begin
                unique case (i_data)
                    btl_pkg::CH_LPAREN, btl_pkg::CH_LSQ, btl_pkg::CH_LBRACE,
                    btl_pkg::CH_RPAREN, btl_pkg::CH_RSQ, btl_pkg::CH_RBRACE: begin
                        civ = 1'b1;
                        ci  = btl_pkg::mk_token(btl_pkg::KIND_NONE, r_pos, 32'd1, r_line,
                                                btl_pkg::ST_OK);
                        unique case (i_data)
                            btl_pkg::CH_LPAREN: ci.kind = btl_pkg::KIND_OPEN_PAREN;
                            btl_pkg::CH_LSQ:    ci.kind = btl_pkg::KIND_OPEN_SQUARE;
                            btl_pkg::CH_LBRACE: ci.kind = btl_pkg::KIND_OPEN_BRACE;
                            btl_pkg::CH_RPAREN: ci.kind = btl_pkg::KIND_CLOSE_PAREN;
                            btl_pkg::CH_RSQ:    ci.kind = btl_pkg::KIND_CLOSE_SQUARE;
                            default:            ci.kind = btl_pkg::KIND_CLOSE_BRACE;
                        endcase
                    end
                    btl_pkg::CH_DQUOTE, btl_pkg::CH_SQUOTE: begin
                        n_mode    = btl_pkg::MODE_STR;
                        n_qsingle = (i_data == btl_pkg::CH_SQUOTE);
                        n_esc     = 1'b0;
                        n_start   = r_pos + 32'd1;
                    end
                    btl_pkg::CH_COMMA, btl_pkg::CH_SEMI: begin
                        civ = 1'b1;
                        ci  = btl_pkg::mk_token(btl_pkg::KIND_TEXT, r_pos, 32'd1, r_line,
                                                btl_pkg::ST_OK);
                    end
                    btl_pkg::CH_SLASH: begin
                        n_held  = btl_pkg::HELD_SLASH;
                        n_start = r_pos;
                    end
                    default: begin
                        n_mode  = btl_pkg::MODE_TEXT;
                        n_start = r_pos;
                    end
                endcase
            end
        end

        // end of source: flush whatever is open, using the updated line count
        if (i_last) begin
            if (n_mode == btl_pkg::MODE_TEXT) begin
                cfv = 1'b1;
                cf  = btl_pkg::mk_token(btl_pkg::KIND_TEXT, n_start, n_pos - n_start, n_line,
                                        btl_pkg::ST_OK);
            end else if (n_mode == btl_pkg::MODE_IDLE && n_held == btl_pkg::HELD_SLASH) begin
                cfv = 1'b1;
                cf  = btl_pkg::mk_token(btl_pkg::KIND_TEXT, n_start, 32'd1, n_line,
                                        btl_pkg::ST_OK);
            end else if (n_mode == btl_pkg::MODE_STR) begin
                cfv = 1'b1;
                cf  = btl_pkg::mk_token(btl_pkg::KIND_STRING, n_start, n_pos - n_start, n_line,
                                        btl_pkg::ST_UNTERM_STR);
            end else if (!c0v && !civ) begin
                cfv = 1'b1;
                cf  = btl_pkg::mk_token(btl_pkg::KIND_NONE, 32'd0, 32'd0, n_line,
                                        btl_pkg::ST_OK);
            end
        end

        // pack the first two candidates into the push slots
        priority if (c0v) begin
            o_push.slot0 = c0;
            o_push.slot1 = civ ? ci : cf;
            o_push.count = (civ || cfv) ? 2'd2 : 2'd1;
        end else if (civ) begin
            o_push.slot0 = ci;
            o_push.slot1 = cf;
            o_push.count = cfv ? 2'd2 : 2'd1;
        end else if (cfv) begin
            o_push.slot0 = cf;
            o_push.count = 2'd1;
        end else begin
            o_push.count = 2'd0;
        end
        if (i_last) begin
            if (o_push.count == 2'd2) begin
                o_push.slot1.final_flag = 1'b1;
            end else begin
                o_push.slot0.final_flag = 1'b1;
            end
            n_mode    = btl_pkg::MODE_IDLE;
            n_held    = btl_pkg::HELD_NONE;
            n_pos     = 32'd0;
            n_line    = 32'd1;
            n_start   = 32'd0;
            n_qsingle = 1'b0;
            n_esc     = 1'b0;
            n_depth   = '0;
        end
        if (!i_fire) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= btl_pkg::MODE_IDLE;
            r_held    <= btl_pkg::HELD_NONE;
            r_pos     <= 32'd0;
            r_line    <= 32'd1;
            r_start   <= 32'd0;
            r_qsingle <= 1'b0;
            r_esc     <= 1'b0;
            r_depth   <= '0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_held    <= n_held;
            r_pos     <= n_pos;
            r_line    <= n_line;
            r_start   <= n_start;
            r_qsingle <= n_qsingle;
            r_esc     <= n_esc;
            r_depth   <= n_depth;
        end
    end

`include "assert_macros.svh"
    `BTL_ASSERT_NEXT(a_last_resets, i_fire && i_last, r_pos == 32'd0 && r_line == 32'd1)
    `BTL_ASSERT_ALWAYS(a_depth_bound, r_depth <= MAX_D)
    `BTL_ASSERT_IMPL(a_last_gives_result, i_fire && i_last, o_push.count != 2'd0)

endmodule
`default_nettype wire

>>> design/btl_result_queue.sv
`default_nettype none
module btl_result_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire btl_pkg::t_push i_push,
    output logic             o_room,
    btl_token_if.source      o_token
);

    localparam int PTR_W = $clog2(btl_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(btl_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(btl_pkg::QUEUE_DEPTH - 2);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(btl_pkg::QUEUE_DEPTH);

    btl_pkg::t_token    r_mem [btl_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               pop;
    btl_pkg::t_token    head;

    assign head   = r_mem[r_rd];
    assign pop    = o_token.valid && o_token.ready;
    assign o_room = (r_cnt <= ROOM_MAX);

    assign o_token.valid        = (r_cnt != '0);
    assign o_token.token_kind   = head.kind;
    assign o_token.token_offset = head.offset;
    assign o_token.token_length = head.length;
    assign o_token.line_number  = head.line;
    assign o_token.status       = head.status;
    assign o_token.final_result = head.final_flag;

    always_comb begin
        n_wr  = r_wr + PTR_W'(i_push.count);
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 1'b1] <= i_push.slot1;
        end
    end

`include "assert_macros.svh"
    `BTL_ASSERT_ALWAYS(a_cnt_bound, r_cnt <= DEPTH_C)
    `BTL_ASSERT_IMPL(a_push_fits, i_push.count != 2'd0, r_cnt <= ROOM_MAX)

endmodule
`default_nettype wire

>>> design/bracket_text_lexer_top.sv
`default_nettype none
// bracket text lexer: takes one source byte per word on i_byte and returns
// tokens on o_token (text runs, quoted strings, six bracket kinds), skipping
// blanks, line comments and nested block comments, with offset and line
// counters per source. a byte is taken in every cycle while the result queue
// has room for two tokens; every byte is decoded combinationally from the lexer
// state registers and its tokens (none, one or two) go straight into a
// four-entry result queue, so ready stays high as long as the sink takes about
// one token per cycle. a byte that closes a text run with a bracket or comma
// yields two tokens and the sink then drains them one at a time. the
// word flagged end_of_source flushes any open token, always yields at least
// one result (the last one marked final_result) and returns all counters to
// their start values, so the next word begins a new source. an open string at
// the end reports status 1, a nesting past MAX_COMMENT_DEPTH reports status 2.
// an accepted byte's tokens are registered in the queue and reach o_token in order.
module bracket_text_lexer_top #(
    parameter int MAX_COMMENT_DEPTH = btl_pkg::MAX_COMMENT_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    btl_byte_if.sink      i_byte,
    btl_token_if.source   o_token
);

    logic             room;
    logic             fire;
    btl_pkg::t_push   push;

    // accept only while two free queue entries are guaranteed
    assign i_byte.ready = room;
    assign fire         = i_byte.valid && room;

    btl_core #(
        .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_data  (i_byte.data_byte),
        .i_last  (i_byte.end_of_source),
        .o_push  (push)
    );

    // output side is fully registered; stalls here never block the decoder
    // until the queue is down to fewer than two free entries
    btl_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_token (o_token)
    );

endmodule
`default_nettype wire
